/* src/aer_handshake_receiver_unit_macros.svh */
// assertion macros for the address-event receiver
`ifndef AER_HANDSHAKE_RECEIVER_UNIT_MACROS_SVH
`define AER_HANDSHAKE_RECEIVER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define AHR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: ante -> cons");

// next-cycle implication, disabled in reset
`define AHR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: ante => cons");

`endif

/* src/ahr_pkg.sv */
package ahr_pkg;

  localparam int WORD_BITS  = 32;
  localparam int TIMER_BITS = 24;
  localparam int LIMIT_BITS = 24;
  localparam int BUS_W      = 32;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CMP_BITS   = (TIMER_BITS + 1 > LIMIT_BITS) ? TIMER_BITS + 1 : LIMIT_BITS;

  localparam logic [BUS_W-1:0] WORD_MASK = BUS_W'((64'd1 << WORD_BITS) - 64'd1);
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_VALID_LIMIT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_LIMIT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    PH_WAIT_VALID   = 2'b01,
    PH_WAIT_NEUTRAL = 2'b10
  } ahr_phase_t;

  typedef enum logic [1:0] {
    EV_NONE            = 2'd0,
    EV_WORD_DONE       = 2'd1,
    EV_VALID_TIMEOUT   = 2'd2,
    EV_NEUTRAL_TIMEOUT = 2'd3
  } ahr_event_t;

  typedef struct packed {
    logic [BUS_W-1:0] bus_word;
    logic             fifo_full;
  } ahr_item_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [LIMIT_BITS-1:0] data;
  } ahr_cfg_t;

  typedef struct packed {
    logic             ack_level;
    logic             push_valid;
    logic [BUS_W-1:0] push_word;
    ahr_event_t       event_code;
    logic [CNT_W-1:0] good_count;
    logic [CNT_W-1:0] drop_count;
    logic [CNT_W-1:0] valid_timeout_count;
    logic [CNT_W-1:0] neutral_timeout_count;
  } ahr_result_t;

endpackage

/* src/aer_handshake_receiver_unit.sv */
// address-event four-phase handshake receiver
// input channel: in_valid/in_ready with in_bus_word and in_fifo_full, one
//   transaction per sampled tick of the bus
// result channel: out_valid/out_ready, exactly one result transaction per
//   input transaction, in order: ack level, push strobe and word, event code
//   and the four wrapping counters as they stand after that tick
// config port: cfg_we writes cfg_data (24 bits) to the valid wait limit
//   (index 0) or the neutral wait limit (index 1); zero disables a timeout
// path: a taken input is held in the input register, then moves on to the
//   result register, whose valid drives out_valid
// throughput: one transaction per cycle while out_ready is high, set by the
//   combinational phase and counter update between the two registers
// stall: when out_ready is low the result register holds, the input register
//   still takes one more transaction, then in_ready drops until it drains
// reset: a synchronous rst_n low clears both registers' valids, the phase
//   (waiting for valid), the wait timer, ack, all counters and both limits
module aer_handshake_receiver_unit
  import ahr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BUS_W-1:0]      in_bus_word,
  input  logic                  in_fifo_full,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_ack_level,
  output logic                  out_push_valid,
  output logic [BUS_W-1:0]      out_push_word,
  output logic [1:0]            out_event_code,
  output logic [CNT_W-1:0]      out_good_count,
  output logic [CNT_W-1:0]      out_drop_count,
  output logic [CNT_W-1:0]      out_valid_timeout_count,
  output logic [CNT_W-1:0]      out_neutral_timeout_count,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [LIMIT_BITS-1:0] cfg_data
);

  ahr_item_t   in_item;
  ahr_item_t   s1_item;
  logic        s1_valid;
  logic        s1_adv;
  ahr_cfg_t    cfg;
  ahr_result_t res;
  ahr_result_t res_r;
  logic        out_valid_r, out_valid_nxt;

  assign in_item.bus_word  = in_bus_word;
  assign in_item.fifo_full = in_fifo_full;
  assign cfg.we            = cfg_we;
  assign cfg.index         = cfg_index;
  assign cfg.data          = cfg_data;

  assign s1_adv        = s1_valid && (!out_valid_r || out_ready);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_ready);

  ahr_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .adv      (s1_adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  ahr_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (s1_adv),
    .item  (s1_item),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res;
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_ack_level             = res_r.ack_level;
  assign out_push_valid            = res_r.push_valid;
  assign out_push_word             = res_r.push_word;
  assign out_event_code            = res_r.event_code;
  assign out_good_count            = res_r.good_count;
  assign out_drop_count            = res_r.drop_count;
  assign out_valid_timeout_count   = res_r.valid_timeout_count;
  assign out_neutral_timeout_count = res_r.neutral_timeout_count;

endmodule

/* src/ahr_in_stage.sv */
module ahr_in_stage
  import ahr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ahr_item_t in_item,
  input  logic      adv,
  output logic      s1_valid,
  output ahr_item_t s1_item
);

  logic      valid_r;
  logic      valid_nxt;
  ahr_item_t item_r;

  assign in_ready  = !valid_r || adv;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

/* src/ahr_core.sv */
`include "aer_handshake_receiver_unit_macros.svh"

module ahr_core
  import ahr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ahr_cfg_t    cfg,
  input  logic        fire,
  input  ahr_item_t   item,
  output ahr_result_t res
);

  logic [LIMIT_BITS-1:0] vlim_r, nlim_r;
  ahr_phase_t            phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt;
  logic                  ack_r, ack_nxt;
  logic [CNT_W-1:0]      good_r, good_nxt;
  logic [CNT_W-1:0]      drop_r, drop_nxt;
  logic [CNT_W-1:0]      vto_r, vto_nxt;
  logic [CNT_W-1:0]      nto_r, nto_nxt;

  logic [BUS_W-1:0]      word;
  logic                  word_nz;
  logic [LIMIT_BITS-1:0] limit_sel;
  logic [TIMER_BITS:0]   ticked;
  logic                  timed_out;
  logic [TIMER_BITS-1:0] timer_adv;
  logic                  push_v;
  ahr_event_t            ev;

  assign word      = item.bus_word & WORD_MASK;
  assign word_nz   = |word;
  assign limit_sel = (phase_r == PH_WAIT_NEUTRAL) ? nlim_r : vlim_r;
  assign ticked    = {1'b0, elapsed_r} + (TIMER_BITS+1)'(1);
  assign timed_out = (limit_sel != '0) && (CMP_BITS'(ticked) >= CMP_BITS'(limit_sel));
  assign timer_adv = (limit_sel == '0) ? '0 :
                     (ticked[TIMER_BITS] ? TIMER_MAX : ticked[TIMER_BITS-1:0]);

  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    ack_nxt     = ack_r;
    good_nxt    = good_r;
    drop_nxt    = drop_r;
    vto_nxt     = vto_r;
    nto_nxt     = nto_r;
    push_v      = 1'b0;
    ev          = EV_NONE;
    if (fire) begin
      unique case (phase_r)
        PH_WAIT_VALID: begin
          if (word_nz) begin
            ack_nxt     = 1'b1;
            phase_nxt   = PH_WAIT_NEUTRAL;
            elapsed_nxt = '0;
            if (item.fifo_full) begin
              drop_nxt = drop_r + CNT_W'(1);
            end else begin
              push_v = 1'b1;
            end
          end else if (timed_out) begin
            vto_nxt     = vto_r + CNT_W'(1);
            ack_nxt     = 1'b0;
            elapsed_nxt = '0;
            ev          = EV_VALID_TIMEOUT;
          end else begin
            elapsed_nxt = timer_adv;
          end
        end
        PH_WAIT_NEUTRAL: begin
          if (!word_nz) begin
            ack_nxt     = 1'b0;
            good_nxt    = good_r + CNT_W'(1);
            phase_nxt   = PH_WAIT_VALID;
            elapsed_nxt = '0;
            ev          = EV_WORD_DONE;
          end else if (timed_out) begin
            nto_nxt     = nto_r + CNT_W'(1);
            ack_nxt     = 1'b0;
            phase_nxt   = PH_WAIT_VALID;
            elapsed_nxt = '0;
            ev          = EV_NEUTRAL_TIMEOUT;
          end else begin
            elapsed_nxt = timer_adv;
          end
        end
        default: begin
          phase_nxt   = PH_WAIT_VALID;
          elapsed_nxt = '0;
          ack_nxt     = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    res.ack_level             = ack_nxt;
    res.push_valid            = push_v;
    res.push_word             = push_v ? word : '0;
    res.event_code            = ev;
    res.good_count            = good_nxt;
    res.drop_count            = drop_nxt;
    res.valid_timeout_count   = vto_nxt;
    res.neutral_timeout_count = nto_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlim_r    <= '0;
      nlim_r    <= '0;
      phase_r   <= PH_WAIT_VALID;
      elapsed_r <= '0;
      ack_r     <= 1'b0;
      good_r    <= '0;
      drop_r    <= '0;
      vto_r     <= '0;
      nto_r     <= '0;
    end else begin
      if (cfg.we) begin
        unique case (cfg.index)
          REG_VALID_LIMIT:   vlim_r <= cfg.data;
          REG_NEUTRAL_LIMIT: nlim_r <= cfg.data;
          default: ;
        endcase
      end
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      ack_r     <= ack_nxt;
      good_r    <= good_nxt;
      drop_r    <= drop_nxt;
      vto_r     <= vto_nxt;
      nto_r     <= nto_nxt;
    end
  end

  // ack is held exactly while waiting for the bus to go neutral
  `AHR_ASSERT_NOW(a_ack_tracks_phase, 1'b1, ack_r == (phase_r == PH_WAIT_NEUTRAL))
  // every event leaves the timer cleared and the machine waiting for valid
  `AHR_ASSERT_NEXT(a_event_restarts, fire && (ev != EV_NONE), (elapsed_r == '0) && (phase_r == PH_WAIT_VALID))
  // a push only happens on a latch from the valid wait
  `AHR_ASSERT_NOW(a_push_on_latch, fire && push_v, (phase_r == PH_WAIT_VALID) && ack_nxt && !item.fifo_full)
  // no state moves without a transaction
  `AHR_ASSERT_NEXT(a_hold_when_idle, !fire && !cfg.we, $stable(phase_r) && $stable(elapsed_r) && $stable(good_r))

endmodule

/* verif/tb_aer_handshake_receiver_unit.sv */
`timescale 1ns / 1ps

module tb_aer_handshake_receiver_unit;
  import ahr_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [BUS_W-1:0]      in_bus_word = '0;
  logic                  in_fifo_full = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_ack_level;
  logic                  out_push_valid;
  logic [BUS_W-1:0]      out_push_word;
  logic [1:0]            out_event_code;
  logic [CNT_W-1:0]      out_good_count;
  logic [CNT_W-1:0]      out_drop_count;
  logic [CNT_W-1:0]      out_valid_timeout_count;
  logic [CNT_W-1:0]      out_neutral_timeout_count;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [LIMIT_BITS-1:0] cfg_data = '0;

  aer_handshake_receiver_unit u_top (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_bus_word              (in_bus_word),
    .in_fifo_full             (in_fifo_full),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_ack_level            (out_ack_level),
    .out_push_valid           (out_push_valid),
    .out_push_word            (out_push_word),
    .out_event_code           (out_event_code),
    .out_good_count           (out_good_count),
    .out_drop_count           (out_drop_count),
    .out_valid_timeout_count  (out_valid_timeout_count),
    .out_neutral_timeout_count(out_neutral_timeout_count),
    .cfg_we                   (cfg_we),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data)
  );

  always #5 clk = ~clk;

  // receiver shadow state
  logic [LIMIT_BITS-1:0] valid_limit = '0;
  logic [LIMIT_BITS-1:0] neutral_limit = '0;
  ahr_phase_t            rx_phase = PH_WAIT_VALID;
  logic [TIMER_BITS-1:0] wait_ticks = '0;
  logic                  ack_now = 1'b0;
  logic [CNT_W-1:0]      good_total = '0;
  logic [CNT_W-1:0]      drop_total = '0;
  logic [CNT_W-1:0]      valid_timeouts = '0;
  logic [CNT_W-1:0]      neutral_timeouts = '0;

  ahr_result_t awaited_results[$];
  int          error_count = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;
  int          rx_hold_left = 0;

  function automatic logic wait_expired(input logic [LIMIT_BITS-1:0] lim);
    logic [TIMER_BITS:0] nxt;
    if (lim == '0) begin
      wait_ticks = '0;
      return 1'b0;
    end
    nxt = {1'b0, wait_ticks} + (TIMER_BITS+1)'(1);
    if (nxt >= lim) return 1'b1;
    if (nxt > {1'b0, TIMER_MAX}) nxt = {1'b0, TIMER_MAX};
    wait_ticks = nxt[TIMER_BITS-1:0];
    return 1'b0;
  endfunction

  function automatic ahr_result_t next_receiver_result(input logic [BUS_W-1:0] bus,
                                                       input logic full);
    ahr_result_t r;
    logic [BUS_W-1:0] word;
    word = bus & WORD_MASK;
    r = '0;
    r.event_code = EV_NONE;
    if (rx_phase == PH_WAIT_VALID) begin
      if (word != '0) begin
        ack_now = 1'b1;
        if (full) begin
          drop_total = drop_total + CNT_W'(1);
        end else begin
          r.push_valid = 1'b1;
          r.push_word = word;
        end
        rx_phase = PH_WAIT_NEUTRAL;
        wait_ticks = '0;
      end else if (wait_expired(valid_limit)) begin
        valid_timeouts = valid_timeouts + CNT_W'(1);
        ack_now = 1'b0;
        wait_ticks = '0;
        r.event_code = EV_VALID_TIMEOUT;
      end
    end else begin
      if (word == '0) begin
        ack_now = 1'b0;
        good_total = good_total + CNT_W'(1);
        rx_phase = PH_WAIT_VALID;
        wait_ticks = '0;
        r.event_code = EV_WORD_DONE;
      end else if (wait_expired(neutral_limit)) begin
        neutral_timeouts = neutral_timeouts + CNT_W'(1);
        ack_now = 1'b0;
        rx_phase = PH_WAIT_VALID;
        wait_ticks = '0;
        r.event_code = EV_NEUTRAL_TIMEOUT;
      end
    end
    r.ack_level = ack_now;
    r.good_count = good_total;
    r.drop_count = drop_total;
    r.valid_timeout_count = valid_timeouts;
    r.neutral_timeout_count = neutral_timeouts;
    return r;
  endfunction

  // result side ready, with an optional long hold-off
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      out_ready <= 1'b0;
      rx_hold_left = rx_hold_left - 1;
    end else if (rx_gaps_on) begin
      out_ready <= ($urandom_range(99) >= 16);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    ahr_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result transaction with nothing expected");
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("ack_level", 32'(want.ack_level), 32'(out_ack_level));
        check_field("push_valid", 32'(want.push_valid), 32'(out_push_valid));
        check_field("push_word", want.push_word, out_push_word);
        check_field("event_code", 32'(want.event_code), 32'(out_event_code));
        check_field("good_count", want.good_count, out_good_count);
        check_field("drop_count", want.drop_count, out_drop_count);
        check_field("valid_timeout_count", want.valid_timeout_count,
                    out_valid_timeout_count);
        check_field("neutral_timeout_count", want.neutral_timeout_count,
                    out_neutral_timeout_count);
      end
    end
  end

  task automatic send_tick(input logic [BUS_W-1:0] bus, input logic full);
    while (tx_gaps_on && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_bus_word <= bus;
    in_fifo_full <= full;
    do @(posedge clk); while (!in_ready);
    awaited_results.push_back(next_receiver_result(bus, full));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic set_limits(input logic [LIMIT_BITS-1:0] v_lim,
                            input logic [LIMIT_BITS-1:0] n_lim);
    cfg_we <= 1'b1;
    cfg_index <= REG_VALID_LIMIT;
    cfg_data <= v_lim;
    @(posedge clk);
    cfg_index <= REG_NEUTRAL_LIMIT;
    cfg_data <= n_lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    valid_limit = v_lim;
    neutral_limit = n_lim;
  endtask

  function automatic logic [BUS_W-1:0] request_word();
    logic [BUS_W-1:0] w;
    case ($urandom_range(3))
      0: w = $urandom;
      1: w = 32'h1 << $urandom_range(31);
      2: w = ~(32'h1 << $urandom_range(31));
      default: w = $urandom & 32'hff;
    endcase
    return (w == '0) ? 32'h1 : w;
  endfunction

  function automatic int wait_span(input logic [LIMIT_BITS-1:0] lim);
    return (lim == '0 || lim > 10) ? 6 : int'(lim) + 1;
  endfunction

  // mostly well-formed request/neutral sequences, some noise
  task automatic run_handshakes(input int n_ticks);
    int sent;
    int gap;
    int hold;
    logic [BUS_W-1:0] w;
    sent = 0;
    while (sent < n_ticks) begin
      if ($urandom_range(9) == 0) begin
        send_tick($urandom_range(1) ? request_word() : '0, 1'($urandom_range(1)));
        sent++;
      end else begin
        gap = $urandom_range(wait_span(valid_limit));
        hold = $urandom_range(1, wait_span(neutral_limit));
        w = request_word();
        repeat (gap) send_tick('0, $urandom_range(3) == 0);
        repeat (hold) send_tick(w, $urandom_range(3) == 0);
        sent += gap + hold;
      end
    end
    wait_for_results();
  endtask

  task automatic test_directed();
    // limits at reset: both waits disabled
    send_tick('0, 1'b0);
    send_tick(32'hffff_ffff, 1'b0);
    send_tick(32'hffff_ffff, 1'b0);
    send_tick('0, 1'b0);
    send_tick(32'h1, 1'b1);
    send_tick('0, 1'b1);
    send_tick(32'h8000_0000, 1'b0);
    send_tick('0, 1'b0);
    wait_for_results();
    set_limits(24'd1, 24'd1);
    send_tick('0, 1'b0);
    send_tick('0, 1'b1);
    send_tick(32'h5, 1'b0);
    send_tick(32'h5, 1'b0);
    send_tick(32'h5, 1'b1);
    send_tick('0, 1'b0);
    wait_for_results();
    set_limits(24'd3, 24'd2);
    send_tick('0, 1'b0);
    send_tick('0, 1'b0);
    send_tick('0, 1'b0);
    send_tick(32'h1234_5678, 1'b0);
    send_tick(32'h1234_5678, 1'b0);
    send_tick(32'h1234_5678, 1'b0);
    send_tick('0, 1'b0);
    wait_for_results();
    set_limits(24'hff_ffff, 24'hff_ffff);
    send_tick('0, 1'b0);
    send_tick(32'hdead_beef, 1'b1);
    send_tick(32'hdead_beef, 1'b0);
    send_tick('0, 1'b0);
    wait_for_results();
  endtask

  task automatic test_random_handshakes();
    set_limits('0, '0);
    run_handshakes(80);
    set_limits(24'd1, 24'd1);
    run_handshakes(80);
    set_limits(24'd2, 24'd5);
    run_handshakes(80);
    // long stretch with no idling on either side
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    set_limits(LIMIT_BITS'($urandom_range(1, 8)), LIMIT_BITS'($urandom_range(1, 8)));
    run_handshakes(120);
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    set_limits(24'hff_ffff, 24'hff_ffff);
    run_handshakes(30);
    set_limits(LIMIT_BITS'($urandom_range(1, 8)), '0);
    run_handshakes(70);
    set_limits('0, LIMIT_BITS'($urandom_range(1, 8)));
    run_handshakes(70);
    set_limits(LIMIT_BITS'($urandom_range(1000, 24'hff_ffff)), 24'd1);
    run_handshakes(50);
  endtask

  task automatic test_backpressure();
    set_limits(24'd4, 24'd3);
    tx_gaps_on = 1'b0;
    rx_hold_left = 80;
    run_handshakes(60);
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    set_limits(24'd3, 24'd3);
    run_handshakes(30);
    run_handshakes(30);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_handshakes();
    test_backpressure();
    test_sender_pause();
    wait_for_results();
    repeat (8) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $error("%0d result transactions never arrived", awaited_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
